// ===== rtl/core/lpr_pkg.sv =====
package lpr_pkg;

  // Widths sized for the largest build (64 frames)
  localparam int IDX_W = 6;
  localparam int CFG_W = 4;
  localparam int CNT_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Update broadcast to every frame cell
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_FILL,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      wr;
    idx_t      target;
    idx_t      rank;
  } cmd_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
    idx_t hit_idx;
    idx_t hit_rank;
    logic empty;
    idx_t empty_idx;
    idx_t lru_idx;
    idx_t lru_rank;
  } search_t;

endpackage

// ===== rtl/core/lpr_ifs.sv =====
interface lpr_req_if #(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 last_access;

  modport source (output valid, output page, output last_access, input ready);
  modport sink (input valid, input page, input last_access, output ready);
endinterface

interface lpr_rsp_if #(
  parameter int PAGE_BITS = 16,
  parameter int FIDX_W    = 3
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [FIDX_W-1:0]    frame_index;
  logic                 evicted;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [31:0]          fault_count;
  logic [31:0]          replacement_count;
  logic                 sequence_done;

  modport source (
    output valid, output hit, output frame_index, output evicted, output evicted_page,
    output fault_count, output replacement_count, output sequence_done, input ready
  );
  modport sink (
    input valid, input hit, input frame_index, input evicted, input evicted_page,
    input fault_count, input replacement_count, input sequence_done, output ready
  );
endinterface

// ===== rtl/core/lpr_cell.sv =====
module lpr_cell #(
  parameter int IDX       = 0,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 active,
  input  logic [PAGE_BITS-1:0] req_page,
  input  lpr_pkg::search_t     rec_in,
  input  logic [PAGE_BITS-1:0] lru_page_in,
  output lpr_pkg::search_t     rec_out,
  output logic [PAGE_BITS-1:0] lru_page_out,
  input  lpr_pkg::cmd_t        cmd,
  input  logic [PAGE_BITS-1:0] new_page
);
  import lpr_pkg::*;

  localparam idx_t MY_IDX  = IDX_W'(IDX);
  localparam logic IS_HEAD = (IDX == 0);

  logic                 valid_r;
  idx_t                 rank_r;
  logic [PAGE_BITS-1:0] page_r;
  search_t              rec_r;
  search_t              rec_nxt;
  logic [PAGE_BITS-1:0] lru_page_r;
  logic [PAGE_BITS-1:0] lru_page_nxt;
  logic                 is_target;

  assign is_target = (cmd.target == MY_IDX);

  // Fold this frame into the passing search record
  always_comb begin
    rec_nxt      = rec_in;
    lru_page_nxt = lru_page_in;
    if (rec_in.valid && active) begin
      if (!rec_in.found && valid_r && (page_r == req_page)) begin
        rec_nxt.found    = 1'b1;
        rec_nxt.hit_idx  = MY_IDX;
        rec_nxt.hit_rank = rank_r;
      end
      if (!rec_in.empty && !valid_r) begin
        rec_nxt.empty     = 1'b1;
        rec_nxt.empty_idx = MY_IDX;
      end
      if (IS_HEAD || (rank_r > rec_in.lru_rank)) begin
        rec_nxt.lru_idx  = MY_IDX;
        rec_nxt.lru_rank = rank_r;
        lru_page_nxt     = page_r;
      end
    end
  end

  // Hand the record to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lru_page_r <= lru_page_nxt;
  end

  assign rec_out      = rec_r;
  assign lru_page_out = lru_page_r;

  // Apply the broadcast update: age, promote, fill or clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      case (cmd.kind)
        CMD_TOUCH: begin
          if (is_target) begin
            rank_r <= '0;
          end else if (valid_r && (rank_r < cmd.rank)) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        CMD_FILL: begin
          if (is_target) begin
            valid_r <= 1'b1;
            rank_r  <= '0;
          end else if (valid_r) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        CMD_CLEAR: begin
          valid_r <= 1'b0;
          rank_r  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Page store, written on fill or eviction
  always_ff @(posedge clk) begin
    if (is_target && cmd.wr && ((cmd.kind == CMD_TOUCH) || (cmd.kind == CMD_FILL))) begin
      page_r <= new_page;
    end
  end

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// LRU page replacement engine. Each request carries one page access; the
// block keeps FRAMES frame cells, each holding a page, a valid bit and an
// age rank (0 is most recent). Between acceptance of a request and the next
// acceptance the request is launched, its search record walks the chain of
// frame cells one cell per cycle (first matching frame, first empty frame,
// oldest frame), the record is captured, and the update is committed to all
// cells in parallel while the result register is loaded. The commit waits
// while a previous result has not been taken. cfg_wdata sets how many frames
// take part (0 acts as 1, values above FRAMES act as FRAMES); write it only
// while no request is in flight. A request with last_access set reports the
// final counts and then empties all frames and clears both saturating
// counters.
module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lpr_req_if.sink                    in_ch,
  lpr_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [lpr_pkg::CFG_W-1:0]  cfg_wdata
);
  import lpr_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW     = $clog2(FRAMES + 1);
  localparam int CW     = (NW > CFG_W) ? NW : CFG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     frames_r;
  logic [CW-1:0]        cfg_ext;
  logic [CW-1:0]        n_eff;
  logic [FRAMES-1:0]    active;
  logic                 start_r;
  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;
  search_t              fin_r;
  logic [PAGE_BITS-1:0] fin_page_r;
  cnt_t                 faults_r;
  cnt_t                 repl_r;
  cnt_t                 faults_nxt;
  cnt_t                 repl_nxt;

  search_t              rec [0:FRAMES];
  logic [PAGE_BITS-1:0] lru_page [0:FRAMES];
  logic [FRAMES-1:0]    chain_v;
  cmd_t                 cmd;

  logic                 in_fire;
  logic                 commit;
  logic                 miss;
  logic                 evict;
  idx_t                 frame;

  logic                 out_valid_r;
  logic                 hit_r;
  logic [FIDX_W-1:0]    frame_index_r;
  logic                 evicted_r;
  logic [PAGE_BITS-1:0] evicted_page_r;
  cnt_t                 fault_count_r;
  cnt_t                 repl_count_r;
  logic                 done_r;

  // Frame count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= CFG_RESET;
    end else if (cfg_we) begin
      frames_r <= cfg_wdata;
    end
  end

  // Clamp the frame count into 1..FRAMES
  always_comb begin
    cfg_ext = CW'(frames_r);
    if (cfg_ext == '0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > CW'(FRAMES)) begin
      n_eff = CW'(FRAMES);
    end else begin
      n_eff = cfg_ext;
    end
  end

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign commit      = (state_r == S_COMMIT) && (!out_valid_r || out_ch.ready);

  // Launch an empty search record at the head of the chain
  always_comb begin
    rec[0]       = '0;
    rec[0].valid = start_r;
    lru_page[0]  = '0;
  end

  // Row of frame cells
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign active[i]  = (CW'(i) < n_eff);
    assign chain_v[i] = rec[i+1].valid;

    lpr_cell #(
      .IDX       (i),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .active       (active[i]),
      .req_page     (page_r),
      .rec_in       (rec[i]),
      .lru_page_in  (lru_page[i]),
      .rec_out      (rec[i+1]),
      .lru_page_out (lru_page[i+1]),
      .cmd          (cmd),
      .new_page     (page_r)
    );
  end

  // Choose the frame: hit, else first empty, else oldest
  always_comb begin
    miss  = !fin_r.found;
    evict = miss && !fin_r.empty;
    if (fin_r.found) begin
      frame = fin_r.hit_idx;
    end else if (fin_r.empty) begin
      frame = fin_r.empty_idx;
    end else begin
      frame = fin_r.lru_idx;
    end
    faults_nxt = faults_r;
    if (miss && (faults_r != '1)) begin
      faults_nxt = faults_r + 1'b1;
    end
    repl_nxt = repl_r;
    if (evict && (repl_r != '1)) begin
      repl_nxt = repl_r + 1'b1;
    end
  end

  // Broadcast the update on commit
  always_comb begin
    cmd.kind   = CMD_NONE;
    cmd.wr     = miss;
    cmd.target = frame;
    cmd.rank   = fin_r.found ? fin_r.hit_rank : fin_r.lru_rank;
    if (commit) begin
      if (last_r) begin
        cmd.kind = CMD_CLEAR;
      end else if (fin_r.found || evict) begin
        cmd.kind = CMD_TOUCH;
      end else begin
        cmd.kind = CMD_FILL;
      end
    end
  end

  // Request payload and search capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_r <= in_ch.page;
      last_r <= in_ch.last_access;
    end
    if ((state_r == S_SEARCH) && rec[FRAMES].valid) begin
      fin_r      <= rec[FRAMES];
      fin_page_r <= lru_page[FRAMES];
    end
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      faults_r    <= '0;
      repl_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_fire;
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (rec[FRAMES].valid) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            state_r        <= S_IDLE;
            out_valid_r    <= 1'b1;
            hit_r          <= fin_r.found;
            frame_index_r  <= frame[FIDX_W-1:0];
            evicted_r      <= evict;
            evicted_page_r <= evict ? fin_page_r : '0;
            fault_count_r  <= faults_nxt;
            repl_count_r   <= repl_nxt;
            done_r         <= last_r;
            faults_r       <= last_r ? '0 : faults_nxt;
            repl_r         <= last_r ? '0 : repl_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.hit               = hit_r;
  assign out_ch.frame_index       = frame_index_r;
  assign out_ch.evicted           = evicted_r;
  assign out_ch.evicted_page      = evicted_page_r;
  assign out_ch.fault_count       = fault_count_r;
  assign out_ch.replacement_count = repl_count_r;
  assign out_ch.sequence_done     = done_r;

  // A single search record walks the chain at a time
  assert property (@(posedge clk) disable iff (!rst_n) $countones(chain_v) <= 1)
    else $error("more than one search record in the cell chain");

  // A search reaches the chain end only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    rec[FRAMES].valid |-> (state_r == S_SEARCH))
    else $error("search record arrived outside the search phase");

  // Replacements never outnumber faults
  assert property (@(posedge clk) disable iff (!rst_n) repl_r <= faults_r)
    else $error("replacement count exceeds fault count");

  // End of sequence clears both counters
  assert property (@(posedge clk) disable iff (!rst_n)
    (commit && last_r) |=> ((faults_r == '0) && (repl_r == '0)))
    else $error("counters not cleared after last access");

endmodule
